@@ sv/mfp_pkg.sv @@
// Shared types and constants of the multilink fragment planner.
package mfp_pkg;

	// Field widths fixed by the stream formats.
	localparam int LEN_W = 12;
	localparam int SEQ_W = 24;
	localparam int SEQ_SHORT_W = 12;
	localparam int CH_FIELD_W = 3;
	localparam int IN_DATA_W = 72;
	localparam int OUT_DATA_W = 56;

	// Fragment limits and header sizes.
	localparam int MAX_RES = 32;
	localparam int CNT_W = $clog2(MAX_RES + 1);
	localparam logic [2:0] HDR_SHORT = 3'd4;
	localparam logic [2:0] HDR_LONG = 3'd6;
	localparam logic [2:0] HDR_ADDR_CTL = 3'd2;
	localparam int MTU_MIN = 4;
	localparam logic [15:0] MTU_RESET = 16'd1500;

	// Configuration register indexes.
	localparam logic [0:0] CFG_SHORT_SEQ = 1'b0;
	localparam logic [0:0] CFG_COMPRESS = 1'b1;

	// Input item selector.
	localparam logic ACT_STATUS = 1'b0;

	// Result kinds.
	typedef enum logic [1:0] {
		KIND_FRAGMENT = 2'd0,
		KIND_DEFERRED = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// Per-channel availability during one packet.
	typedef enum logic [1:0] {
		AV_NONE = 2'd0,
		AV_BUSY = 2'd1,
		AV_FREE = 2'd2
	} avail_t;

endpackage

@@ sv/mfp_divider.sv @@
// Shared restoring divider, one quotient bit per cycle.
module mfp_divider #(
	parameter int WIDTH = 40
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             busy,
	output logic             done,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder
);
	localparam int CW = $clog2(WIDTH + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] quo_q;
	logic [WIDTH-1:0] dvs_q;
	logic [WIDTH:0]   shifted;
	logic             fits;

	// One trial subtraction per cycle.
	assign shifted = {rem_q, quo_q[WIDTH-1]};
	assign fits = shifted >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath registers carry no reset.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? WIDTH'(shifted - {1'b0, dvs_q}) : shifted[WIDTH-1:0];
			quo_q <= {quo_q[WIDTH-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quotient = quo_q;
	assign remainder = rem_q;

endmodule

@@ sv/multilink_fragment_planner_core.sv @@
// Multilink fragment planner: channel table, sequencer and result register.
//
// Input stream s_*: s_tuser selects a channel status update (0) or a packet (1).
// A status update writes one channel entry and answers one status result.
// A packet is either deferred (one result) or split into up to 32 fragment
// descriptors across the channels, round-robin from the saved start channel.
// Output stream m_*: m_tuser is the result kind, m_tlast marks the final
// result of an input item. Configuration writes are to arrive on cfg_* only
// while idle; the block itself does not enforce this. s_tready is high only
// while idle. A packet runs a scan of the table, then one division for the
// remainder split, then per visited channel up to three divisions, all on the
// one shared divider, WIDTH = 32 + 2*clog2(CHANNELS+1) (40 for 8 channels).
// Each fragment is held one step so the last one can carry m_tlast; when the
// receiver stalls, the sequencer waits with the next result.
// Reset clears the channel table (MTU 1500, queues empty), the start channel,
// the sequence number and the registers (24-bit sequence, compression on).
module multilink_fragment_planner_core #(
	parameter int CHANNELS = 8,
	parameter int PACKET_MAX = 2048
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// channel_index, channel_attached, channel_speed, channel_mtu,
	// channel_queue_empty, channel_fragment_clear, packet_length,
	// first_byte_zero, zero pad
	input  logic [mfp_pkg::IN_DATA_W-1:0] s_tdata,
	// action
	input  logic                      s_tuser,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// channel, offset, fragment_length, begin_flag, end_flag,
	// sequence_res, zero pad
	output logic [mfp_pkg::OUT_DATA_W-1:0] m_tdata,
	// kind
	output logic [1:0]                m_tuser,
	output logic                      m_tlast,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [0:0]                cfg_index,
	input  logic [0:0]                cfg_data
);
	import mfp_pkg::*;

	localparam int NW = $clog2(CHANNELS + 1);
	localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = 32 + NW;
	localparam int DW = SW + NW;
	localparam int FW = DW + 2;
	localparam int BW = NW + 2;
	localparam int GUARD = (CHANNELS + 1) * (MAX_RES + CHANNELS + 2);
	localparam int GW = $clog2(GUARD + 1);
	localparam int SUM_W = LEN_W + NW + 3;

	typedef enum logic [13:0] {
		ST_IDLE   = 14'b00000000000001,
		ST_STAT   = 14'b00000000000010,
		ST_SCAN   = 14'b00000000000100,
		ST_DECIDE = 14'b00000000001000,
		ST_MODW   = 14'b00000000010000,
		ST_STEP   = 14'b00000000100000,
		ST_W0     = 14'b00000001000000,
		ST_W1     = 14'b00000010000000,
		ST_W2     = 14'b00000100000000,
		ST_XTRA   = 14'b00001000000000,
		ST_W3     = 14'b00010000000000,
		ST_CLAMP  = 14'b00100000000000,
		ST_EMIT   = 14'b01000000000000,
		ST_FINISH = 14'b10000000000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic short_q;
	logic compress_q;

	// Channel table.
	logic        att_q [CHANNELS];
	logic [31:0] spd_q [CHANNELS];
	logic [15:0] mtu_q [CHANNELS];
	logic        qe_q [CHANNELS];
	logic        had_q [CHANNELS];
	avail_t      avail_q [CHANNELS];
	logic [NW-1:0]    next_ch_q;
	logic [SEQ_W-1:0] seq_q;

	// Per-packet state.
	logic [LEN_W-1:0] len_in_q;
	logic             fbz_q;
	logic [NW-1:0]    scan_q;
	logic [NW-1:0]    navail_q;
	logic [NW-1:0]    nfree_q;
	logic [NW-1:0]    totfree_q;
	logic [NW-1:0]    nzero_q;
	logic [SW-1:0]    totspeed_q;
	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] totlen_q;
	logic [LEN_W-1:0] off_q;
	logic signed [BW-1:0] nbigger_q;
	logic [NW-1:0]    cur_q;
	logic [CW-1:0]    c_q;
	logic [CNT_W-1:0] count_q;
	logic [GW-1:0]    guard_q;
	logic             begin_q;
	logic signed [FW-1:0] flen_q;
	kind_t            kind_q;

	// Held fragment and output register.
	logic                  pend_valid_q;
	logic [OUT_DATA_W-1:0] pend_q;
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	kind_t                 out_kind_q;
	logic                  out_last_q;

	// Divider interface.
	logic          div_go_q;
	logic [DW-1:0] div_a_q;
	logic [DW-1:0] div_b_q;
	logic          div_busy;
	logic          div_done;
	logic [DW-1:0] div_quo;
	logic [DW-1:0] div_rem;

	mfp_divider #(
		.WIDTH(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	// Input field extraction.
	logic [2:0]       in_idx;
	logic             in_att;
	logic [31:0]      in_spd;
	logic [15:0]      in_mtu;
	logic             in_qe;
	logic             in_clr;
	logic [LEN_W-1:0] in_len;
	logic             in_fbz;

	assign in_idx = s_tdata[2:0];
	assign in_att = s_tdata[3];
	assign in_spd = s_tdata[35:4];
	assign in_mtu = s_tdata[51:36];
	assign in_qe  = s_tdata[52];
	assign in_clr = s_tdata[53];
	assign in_len = s_tdata[65:54];
	assign in_fbz = s_tdata[66];

	// Derived operands.
	logic [2:0]       hdr_w;
	logic [NW-1:0]    tf_nz_w;
	logic [SUM_W-1:0] lensum_w;
	logic [DW-1:0]    num_w;
	logic [DW-1:0]    ts_tf_w;
	logic [DW-1:0]    xnum_w;
	logic [CW-1:0]    scan_c;
	logic [CW-1:0]    cur_c;
	logic             slot_free;
	logic             step_go;
	logic [LEN_W-1:0] len_cap_w;
	logic             nb_pos;
	logic signed [FW-1:0] len_s;
	logic signed [FW-1:0] clamp_w;
	logic signed [17:0]   mtu_eff_w;
	logic signed [FW-1:0] capped_w;
	logic [LEN_W-1:0]     flen_u;
	logic [SEQ_W-1:0]     seq_out;
	logic [OUT_DATA_W-1:0] frag_w;

	assign hdr_w = short_q ? HDR_SHORT : HDR_LONG;
	assign tf_nz_w = totfree_q - nzero_q;
	assign lensum_w = SUM_W'(totlen_q) + SUM_W'(hdr_w * totfree_q);
	assign num_w = DW'(tf_nz_w) * DW'(lensum_w);
	assign ts_tf_w = DW'(totspeed_q) * DW'(totfree_q);
	assign xnum_w = DW'(tf_nz_w) * DW'(spd_q[c_q]);
	assign scan_c = scan_q[CW-1:0];
	assign cur_c = cur_q[CW-1:0];
	assign slot_free = !out_valid_q || m_tready;
	assign step_go = (len_q != '0) && (count_q < CNT_W'(MAX_RES)) && (guard_q != '0);
	assign len_cap_w = (32'(len_in_q) > PACKET_MAX) ? LEN_W'(PACKET_MAX) : len_in_q;
	assign nb_pos = !nbigger_q[BW-1] && (nbigger_q != '0);
	assign len_s = $signed(FW'(len_q));

	// Fragment size clamp, then the MTU cap less header overhead.
	assign clamp_w = ((nfree_q == '0) || (flen_q > len_s)) ? len_s : flen_q;
	always_comb begin
		mtu_eff_w = $signed({2'b00, mtu_q[c_q]}) - $signed(18'(hdr_w - HDR_ADDR_CTL));
		if (mtu_eff_w < 18'sd4)
			mtu_eff_w = 18'(MTU_MIN);
		capped_w = (clamp_w > FW'(mtu_eff_w)) ? FW'(mtu_eff_w) : clamp_w;
	end

	assign flen_u = flen_q[LEN_W-1:0];
	assign seq_out = short_q ? {{(SEQ_W-SEQ_SHORT_W){1'b0}}, seq_q[SEQ_SHORT_W-1:0]} : seq_q;
	assign frag_w = {3'b000, seq_out, (flen_u == len_q), begin_q, flen_u, off_q,
		CH_FIELD_W'(c_q)};

	// Configuration port.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= 1'b0;
			compress_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_SHORT_SEQ: short_q <= cfg_data[0];
				CFG_COMPRESS:  compress_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sequencer, table and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < CHANNELS; i++) begin
				att_q[i] <= 1'b0;
				spd_q[i] <= '0;
				mtu_q[i] <= MTU_RESET;
				qe_q[i] <= 1'b1;
				had_q[i] <= 1'b0;
				avail_q[i] <= AV_NONE;
			end
			next_ch_q <= '0;
			seq_q <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
			div_go_q <= 1'b0;
			count_q <= '0;
		end else begin
			div_go_q <= 1'b0;
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (s_tuser == ACT_STATUS) begin
							if (32'(in_idx) < CHANNELS) begin
								att_q[in_idx[CW-1:0]] <= in_att;
								spd_q[in_idx[CW-1:0]] <= in_spd;
								mtu_q[in_idx[CW-1:0]] <= in_mtu;
								qe_q[in_idx[CW-1:0]] <= in_qe;
								if (in_clr)
									had_q[in_idx[CW-1:0]] <= 1'b0;
							end
							kind_q <= KIND_STATUS;
							state_q <= ST_STAT;
						end else begin
							len_in_q <= in_len;
							fbz_q <= in_fbz;
							scan_q <= '0;
							navail_q <= '0;
							nfree_q <= '0;
							nzero_q <= '0;
							totspeed_q <= '0;
							state_q <= ST_SCAN;
						end
					end
				end
				ST_STAT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= kind_q;
						out_data_q <= '0;
						out_last_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				// One table entry per cycle.
				ST_SCAN: begin
					if (att_q[scan_c]) begin
						navail_q <= navail_q + 1'b1;
						if (qe_q[scan_c] || !had_q[scan_c]) begin
							if (spd_q[scan_c] == '0)
								nzero_q <= nzero_q + 1'b1;
							else
								totspeed_q <= totspeed_q + SW'(spd_q[scan_c]);
							nfree_q <= nfree_q + 1'b1;
							avail_q[scan_c] <= AV_FREE;
						end else begin
							avail_q[scan_c] <= AV_BUSY;
						end
						if (!had_q[scan_c] && (scan_q < next_ch_q))
							next_ch_q <= scan_q;
					end else begin
						avail_q[scan_c] <= AV_NONE;
					end
					scan_q <= scan_q + 1'b1;
					if (32'(scan_q) == CHANNELS - 1)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if ((nfree_q == '0) || (nfree_q < (navail_q >> 1))) begin
						kind_q <= KIND_DEFERRED;
						state_q <= ST_STAT;
					end else begin
						totfree_q <= nfree_q;
						if ((len_cap_w != '0) && fbz_q && compress_q) begin
							off_q <= LEN_W'(1);
							len_q <= len_cap_w - 1'b1;
							totlen_q <= len_cap_w - 1'b1;
							div_a_q <= DW'(len_cap_w - 1'b1);
						end else begin
							off_q <= '0;
							len_q <= len_cap_w;
							totlen_q <= len_cap_w;
							div_a_q <= DW'(len_cap_w);
						end
						div_b_q <= DW'(nfree_q);
						div_go_q <= 1'b1;
						state_q <= ST_MODW;
					end
				end
				ST_MODW: begin
					if (div_done) begin
						nbigger_q <= BW'(div_rem);
						cur_q <= next_ch_q;
						begin_q <= 1'b1;
						count_q <= '0;
						guard_q <= GW'(GUARD);
						state_q <= ST_STEP;
					end
				end
				// Round-robin walk over the channels.
				ST_STEP: begin
					if (!step_go) begin
						state_q <= ST_FINISH;
					end else begin
						guard_q <= guard_q - 1'b1;
						if (32'(cur_q) == CHANNELS) begin
							cur_q <= '0;
						end else begin
							cur_q <= cur_q + 1'b1;
							c_q <= cur_c;
							if ((avail_q[cur_c] != AV_NONE) &&
								!((avail_q[cur_c] == AV_BUSY) && (nfree_q != '0))) begin
								avail_q[cur_c] <= AV_BUSY;
								if (nfree_q == '0) begin
									flen_q <= len_s;
									state_q <= ST_CLAMP;
								end else if (spd_q[cur_c] == '0) begin
									div_a_q <= DW'(len_q);
									div_b_q <= DW'(nfree_q);
									div_go_q <= 1'b1;
									state_q <= ST_W0;
								end else begin
									div_a_q <= ts_tf_w;
									div_b_q <= DW'(spd_q[cur_c]);
									div_go_q <= 1'b1;
									state_q <= ST_W1;
								end
							end
						end
					end
				end
				// Even share of the remaining length.
				ST_W0: begin
					if (div_done) begin
						flen_q <= $signed(FW'(div_quo)) + $signed(FW'(nb_pos));
						nbigger_q <= nbigger_q - $signed(BW'(nb_pos));
						nfree_q <= nfree_q - 1'b1;
						state_q <= ST_CLAMP;
					end
				end
				// Speed-weighted share: divisor first, then the share.
				ST_W1: begin
					if (div_done) begin
						if (div_quo != '0) begin
							div_a_q <= num_w;
							div_b_q <= div_quo;
							div_go_q <= 1'b1;
							state_q <= ST_W2;
						end else begin
							flen_q <= len_s;
							state_q <= ST_XTRA;
						end
					end
				end
				ST_W2: begin
					if (div_done) begin
						flen_q <= $signed(FW'(div_quo)) - $signed(FW'(hdr_w));
						state_q <= ST_XTRA;
					end
				end
				ST_XTRA: begin
					if (nb_pos && (totspeed_q != '0)) begin
						div_a_q <= xnum_w;
						div_b_q <= DW'(totspeed_q);
						div_go_q <= 1'b1;
						state_q <= ST_W3;
					end else begin
						nfree_q <= nfree_q - 1'b1;
						state_q <= ST_CLAMP;
					end
				end
				ST_W3: begin
					if (div_done) begin
						flen_q <= flen_q + $signed(FW'(div_quo));
						nbigger_q <= nbigger_q - $signed(BW'(div_quo));
						nfree_q <= nfree_q - 1'b1;
						state_q <= ST_CLAMP;
					end
				end
				ST_CLAMP: begin
					if (clamp_w <= 0) begin
						avail_q[c_q] <= AV_FREE;
						state_q <= ST_STEP;
					end else begin
						flen_q <= capped_w;
						state_q <= ST_EMIT;
					end
				end
				// Hold the new fragment, passing the previous one on.
				ST_EMIT: begin
					if (!pend_valid_q || slot_free) begin
						if (pend_valid_q) begin
							out_valid_q <= 1'b1;
							out_kind_q <= KIND_FRAGMENT;
							out_data_q <= pend_q;
							out_last_q <= 1'b0;
						end
						pend_q <= frag_w;
						pend_valid_q <= 1'b1;
						had_q[c_q] <= 1'b1;
						off_q <= off_q + flen_u;
						len_q <= len_q - flen_u;
						seq_q <= seq_q + 1'b1;
						begin_q <= 1'b0;
						count_q <= count_q + 1'b1;
						state_q <= ST_STEP;
					end
				end
				ST_FINISH: begin
					next_ch_q <= cur_q;
					if (!pend_valid_q) begin
						state_q <= ST_IDLE;
					end else if (slot_free) begin
						out_valid_q <= 1'b1;
						out_kind_q <= KIND_FRAGMENT;
						out_data_q <= pend_q;
						out_last_q <= 1'b1;
						pend_valid_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;
	assign m_tuser = out_kind_q;
	assign m_tlast = out_last_q;

`ifndef SYNTH
	a_div_idle_on_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_go_q |-> !div_busy)
		else $error("divider started while busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RES))
		else $error("fragment count above limit");

	a_frag_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == KIND_FRAGMENT)) |-> (m_tdata[26:15] != '0))
		else $error("empty fragment emitted");

	a_emit_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (flen_q > 0))
		else $error("non-positive fragment length reached emit");
`endif

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the multilink fragment planner core.
`timescale 1ns / 1ps

module testbench;
	import mfp_pkg::*;

	localparam int NCH = 8;
	localparam int PKT_MAX = 2048;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 1500;

	typedef struct {
		logic        action;
		logic [2:0]  idx;
		logic        attached;
		logic [31:0] speed;
		logic [15:0] mtu;
		logic        queue_empty;
		logic        frag_clear;
		logic [11:0] plen;
		logic        first_zero;
		bit          sync;
	} item_t;

	typedef struct {
		kind_t                 kind;
		logic [OUT_DATA_W-1:0] data;
		logic                  last;
	} result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [0:0] cfg_index = '0;
	logic [0:0] cfg_data = '0;

	multilink_fragment_planner_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Shadow of the block state and registers.
	logic        sh_short;
	logic        sh_compress;
	logic        tbl_attached [NCH];
	logic [31:0] tbl_speed [NCH];
	logic [15:0] tbl_mtu [NCH];
	logic        tbl_qempty [NCH];
	logic        tbl_hadfrag [NCH];
	int          start_channel;
	logic [23:0] seq_num;

	item_t   pending_items[$];
	result_t expected_results[$];
	item_t   cur_item;
	int      errors = 0;
	int      send_gap = 0;
	int      recv_stall = 0;
	bit      long_hold_req = 0;
	int      cycles = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [IN_DATA_W-1:0] pack_item(item_t it);
		return {5'b0, it.first_zero, it.plen, it.frag_clear, it.queue_empty, it.mtu,
			it.speed, it.attached, it.idx};
	endfunction

	function automatic void shadow_reset();
		sh_short = 1'b0;
		sh_compress = 1'b1;
		for (int c = 0; c < NCH; c++) begin
			tbl_attached[c] = 1'b0;
			tbl_speed[c] = '0;
			tbl_mtu[c] = MTU_RESET;
			tbl_qempty[c] = 1'b1;
			tbl_hadfrag[c] = 1'b0;
		end
		start_channel = 0;
		seq_num = '0;
	endfunction

	function automatic void push_simple(kind_t k);
		result_t r;
		r.kind = k;
		r.data = '0;
		r.last = 1'b1;
		expected_results.push_back(r);
	endfunction

	// Computes the results one accepted item causes and updates the shadow state.
	function automatic void plan_item(item_t it);
		avail_t  av [NCH];
		longint  navail, nfree, nzero, totfree, totspeed;
		longint  hdr, len, totlen, nbigger, off, i, pos, guard;
		longint  flen, mtu, sp, dv, extra;
		int      c;
		bit      first;
		result_t frags[$];
		result_t r;
		logic [23:0] seq_out;

		navail = 0; nfree = 0; nzero = 0; totfree = 0; totspeed = 0;
		first = 1;
		if (it.action == ACT_STATUS) begin
			c = int'(it.idx);
			if (c < NCH) begin
				tbl_attached[c] = it.attached;
				tbl_speed[c] = it.speed;
				tbl_mtu[c] = it.mtu;
				tbl_qempty[c] = it.queue_empty;
				if (it.frag_clear) tbl_hadfrag[c] = 1'b0;
			end
			push_simple(KIND_STATUS);
			return;
		end

		hdr = sh_short ? HDR_SHORT : HDR_LONG;
		// Rescan the table for available and free channels.
		for (c = 0; c < NCH; c++) begin
			av[c] = AV_NONE;
			if (tbl_attached[c]) begin
				av[c] = AV_BUSY;
				navail++;
				if (tbl_qempty[c] || !tbl_hadfrag[c]) begin
					if (tbl_speed[c] == 0) nzero++;
					else totspeed += longint'(tbl_speed[c]);
					av[c] = AV_FREE;
					nfree++;
					totfree++;
				end
				if (!tbl_hadfrag[c] && c < start_channel) start_channel = c;
			end
		end

		if (nfree == 0 || nfree < navail / 2) begin
			push_simple(KIND_DEFERRED);
			return;
		end

		len = longint'(it.plen);
		if (len > PKT_MAX) len = PKT_MAX;
		off = 0;
		if (len > 0 && it.first_zero && sh_compress) begin
			off = 1;
			len--;
		end
		totlen = len;
		nbigger = len % nfree;

		pos = -1;
		for (i = 0; i < start_channel; ++i) begin
			pos++;
			if (pos >= NCH) begin
				i = 0;
				pos = -1;
				break;
			end
		end

		// Round-robin walk over the channels.
		guard = longint'(NCH + 1) * (MAX_RES + NCH + 2);
		while (len > 0 && frags.size() < MAX_RES && guard > 0) begin
			guard--;
			pos++;
			if (pos >= NCH) begin
				pos = -1;
				i = 0;
				continue;
			end
			c = int'(pos);
			++i;
			if (av[c] == AV_NONE) continue;
			if (av[c] == AV_BUSY) begin
				if (nfree > 0) continue;
			end else begin
				av[c] = AV_BUSY;
			end
			flen = len;
			if (nfree > 0) begin
				sp = longint'(tbl_speed[c]);
				if (sp == 0) begin
					flen = len / nfree;
					if (nbigger > 0) begin
						flen++;
						nbigger--;
					end
				end else begin
					dv = (totspeed * totfree) / sp;
					if (dv > 0)
						flen = ((totfree - nzero) * (totlen + hdr * totfree)) / dv - hdr;
					if (nbigger > 0 && totspeed > 0) begin
						extra = ((totfree - nzero) * sp) / totspeed;
						flen += extra;
						nbigger -= extra;
					end
				end
				nfree--;
			end
			if (nfree <= 0 || flen > len) flen = len;
			if (flen <= 0) begin
				av[c] = AV_FREE;
				continue;
			end
			mtu = longint'(tbl_mtu[c]) - (hdr - HDR_ADDR_CTL);
			if (mtu < MTU_MIN) mtu = MTU_MIN;
			if (flen > mtu) flen = mtu;

			seq_out = sh_short ? {12'b0, seq_num[SEQ_SHORT_W-1:0]} : seq_num;
			r.kind = KIND_FRAGMENT;
			r.data = {3'b0, seq_out, logic'(flen == len), logic'(first),
				flen[LEN_W-1:0], off[LEN_W-1:0], c[CH_FIELD_W-1:0]};
			r.last = 1'b0;
			frags.push_back(r);

			tbl_hadfrag[c] = 1'b1;
			off += flen;
			len -= flen;
			seq_num = seq_num + 24'd1;
			first = 0;
		end
		start_channel = int'(i);

		if (frags.size() > 0) frags[frags.size() - 1].last = 1'b1;
		foreach (frags[k]) expected_results.push_back(frags[k]);
	endfunction

	// Input driver: holds each item until its transaction completes.
	always @(posedge clk) begin
		bit fire;
		bit nv;
		item_t nxt;
		if (arst_n) begin
			fire = s_tvalid && s_tready;
			nv = s_tvalid && !fire;
			if (fire) plan_item(cur_item);
			if (!s_tvalid || fire) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_items.size() > 0 &&
						!(pending_items[0].sync && expected_results.size() != 0)) begin
					nxt = pending_items.pop_front();
					cur_item <= nxt;
					s_tdata <= pack_item(nxt);
					s_tuser <= nxt.action;
					nv = 1;
					send_gap = rand_gap();
				end
			end
			s_tvalid <= nv;
		end
	end

	// Output monitor: checks every result transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		bit rdy;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result kind=%0d data=%h last=%b", $time,
						m_tuser, m_tdata, m_tlast);
					errors++;
				end else begin
					e = expected_results.pop_front();
					if (m_tuser !== e.kind) begin
						$display("%0t: kind expected %0d actual %0d", $time, e.kind, m_tuser);
						errors++;
					end
					if (m_tdata !== e.data) begin
						$display("%0t: data expected %h actual %h", $time, e.data, m_tdata);
						errors++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: last expected %b actual %b", $time, e.last, m_tlast);
						errors++;
					end
				end
			end
			if (long_hold_req) begin
				long_hold_req = 0;
				recv_stall = 600;
			end
			if (recv_stall > 0) begin
				recv_stall--;
				rdy = 0;
			end else if ($urandom_range(0, 99) < 8) begin
				recv_stall = rand_gap();
				rdy = 0;
			end else begin
				rdy = 1;
			end
			m_tready <= rdy;
		end
	end

	function automatic item_t base_item();
		item_t it;
		it.action = 1'($urandom_range(0, 1));
		it.idx = 3'($urandom_range(0, 7));
		it.attached = 1'($urandom_range(0, 1));
		it.speed = $urandom;
		it.mtu = 16'($urandom);
		it.queue_empty = 1'($urandom_range(0, 1));
		it.frag_clear = 1'($urandom_range(0, 1));
		it.plen = 12'($urandom);
		it.first_zero = 1'($urandom_range(0, 1));
		it.sync = 0;
		return it;
	endfunction

	function automatic item_t status_item(int idx, bit att, logic [31:0] sp,
			logic [15:0] mtu, bit qe, bit clr);
		item_t it;
		it = base_item();
		it.action = ACT_STATUS;
		it.idx = 3'(idx);
		it.attached = att;
		it.speed = sp;
		it.mtu = mtu;
		it.queue_empty = qe;
		it.frag_clear = clr;
		return it;
	endfunction

	function automatic item_t packet_item(logic [11:0] plen, bit fz);
		item_t it;
		it = base_item();
		it.action = !ACT_STATUS;
		it.plen = plen;
		it.first_zero = fz;
		return it;
	endfunction

	// Random item shaped so that most packets find enough free channels.
	function automatic item_t random_item();
		item_t it;
		int r;
		it = base_item();
		if ($urandom_range(0, 99) < 45) begin
			it.action = ACT_STATUS;
			it.attached = $urandom_range(0, 99) < 75;
			it.queue_empty = $urandom_range(0, 99) < 75;
			it.frag_clear = $urandom_range(0, 99) < 70;
			case ($urandom_range(0, 4))
				0: it.speed = 0;
				1: it.speed = $urandom_range(1, 1000);
				2: it.speed = 32'hffffffff;
				3: it.speed = 0;
				default: it.speed = $urandom;
			endcase
			r = $urandom_range(0, 9);
			if (r < 4) it.mtu = 16'($urandom_range(68, 300));
			else if (r < 6) it.mtu = MTU_RESET;
			else if (r == 6) it.mtu = 16'hffff;
			else if (r == 7) it.mtu = 16'($urandom_range(0, 67));
		end else begin
			it.action = !ACT_STATUS;
			r = $urandom_range(0, 9);
			if (r < 7) it.plen = 12'($urandom_range(1, 400));
			else if (r < 9) it.plen = 12'($urandom_range(400, 2048));
			else it.plen = $urandom_range(0, 1) ? 12'd0 : 12'($urandom_range(2049, 4095));
		end
		return it;
	endfunction

	task automatic write_reg(logic [0:0] idx, logic [0:0] val);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_SHORT_SEQ) sh_short = val;
		else sh_compress = val;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		item_t it;
		logic [1:0] phase_cfg [4];
		phase_cfg[0] = 2'b01;
		phase_cfg[1] = 2'b10;
		phase_cfg[2] = 2'b11;
		phase_cfg[3] = 2'b00;
		shadow_reset();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(CFG_SHORT_SEQ, phase_cfg[ph][1]);
			write_reg(CFG_COMPRESS, phase_cfg[ph][0]);
			if (ph == 0) begin
				// Directed: no channels, then attach with extreme values.
				pending_items.push_back(packet_item(12'd100, 0));
				pending_items.push_back(status_item(0, 1, 0, 16'd1500, 1, 1));
				pending_items.push_back(status_item(1, 1, 0, 16'd68, 1, 1));
				pending_items.push_back(packet_item(12'd1, 1));
				pending_items.push_back(packet_item(12'd0, 0));
				pending_items.push_back(packet_item(12'd301, 1));
				pending_items.push_back(status_item(2, 1, 32'hffffffff, 16'hffff, 0, 0));
				pending_items.push_back(status_item(3, 1, 32'hffffffff, 16'd100, 1, 0));
				pending_items.push_back(status_item(4, 1, 32'd1, 16'd3, 1, 1));
				pending_items.push_back(packet_item(12'd4095, 0));
				pending_items.push_back(packet_item(12'd2048, 1));
				pending_items.push_back(status_item(5, 0, 32'd5, 16'd0, 0, 0));
				for (int c = 0; c < NCH; c++)
					pending_items.push_back(status_item(c, 1, 0, 16'd10, 0, 0));
				pending_items.push_back(packet_item(12'd2048, 0));
				pending_items.push_back(packet_item(12'd50, 0));
				it = packet_item(12'd700, 0);
				it.sync = 1;
				pending_items.push_back(it);
				pending_items.push_back(status_item(7, 1, 32'd1000, 16'd1500, 1, 1));
			end else begin
				if (ph == 1) long_hold_req = 1;
				for (int k = 0; k < 25; k++) begin
					it = random_item();
					if (k == 20) it.sync = 1;
					pending_items.push_back(it);
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/mfp_pkg.sv
sv/mfp_divider.sv
sv/multilink_fragment_planner_core.sv
verif/testbench.sv
